[rtl/prbs16_pkg.sv]
// prbs16_pkg: word types, codes and LFSR step functions for the PRBS16 generator/checker.
// No dependencies; imported by prbs16_step, prbs16_generator_checker, prbs16_monitor and tb.
package prbs16_pkg;

    typedef struct packed {
        logic [1:0] action;
        logic [7:0] data_byte;
    } t_in_word;

    typedef struct packed {
        logic [31:0] random_value;
        logic        follow_error;
        logic [15:0] errors_seen;
        logic        resyncing;
    } t_out_word;

    typedef struct packed {
        logic [15:0] shift_register;
        logic [4:0]  resync_bits_left;
    } t_lfsr_state;

    typedef struct packed {
        logic count_inc;
        logic count_clear;
    } t_step_ctl;

    localparam logic [1:0] ACT_RUN    = 2'd0;
    localparam logic [1:0] ACT_RESEED = 2'd1;
    localparam logic [1:0] ACT_REINIT = 2'd2;

    localparam logic [2:0] MODE_BIT    = 3'd0;
    localparam logic [2:0] MODE_BYTE   = 3'd1;
    localparam logic [2:0] MODE_HALF   = 3'd2;
    localparam logic [2:0] MODE_WORD   = 3'd3;
    localparam logic [2:0] MODE_FOLLOW = 3'd4;

    localparam logic [1:0] REG_MODE = 2'd0;
    localparam logic [1:0] REG_SEED = 2'd1;

    localparam logic [2:0]  MODE_RESET   = MODE_BYTE;
    localparam logic [15:0] LFSR_INIT    = 16'h0001;
    localparam logic [4:0]  RESYNC_INIT  = 5'd16;
    localparam logic [4:0]  RESYNC_BYTE  = 5'd8;

    function automatic logic [15:0] lfsr_guard(input logic [15:0] r);
        return (r == 16'h0000) ? LFSR_INIT : r;
    endfunction

    function automatic logic [15:0] lfsr_next(input logic [15:0] r);
        logic fb;
        fb = r[0] ^ r[2] ^ r[3] ^ r[5];
        return {fb, r[15:1]};
    endfunction

    function automatic logic [15:0] lfsr_adv8(input logic [15:0] r);
        logic [15:0] v;
        v = r;
        for (int i = 0; i < 8; i++) begin
            v = lfsr_next(v);
        end
        return v;
    endfunction

    function automatic logic [15:0] lfsr_adv16(input logic [15:0] r);
        return lfsr_adv8(lfsr_adv8(r));
    endfunction

endpackage

[rtl/prbs16_step.sv]
// prbs16_step: next LFSR/resync state and result value for one word.
// Depends on prbs16_pkg.
module prbs16_step (
    input  logic [2:0]               i_mode,
    input  logic [15:0]              i_seed,
    input  prbs16_pkg::t_in_word     i_word,
    input  prbs16_pkg::t_lfsr_state  i_state,
    output prbs16_pkg::t_lfsr_state  o_state,
    output prbs16_pkg::t_step_ctl    o_ctl,
    output logic [31:0]              o_value
);
    import prbs16_pkg::*;

    logic [15:0] w_g;
    logic [15:0] w_a1;
    logic [15:0] w_a8;
    logic [15:0] w_a16;
    logic [15:0] w_a32;

    assign w_g   = lfsr_guard(i_state.shift_register);
    assign w_a1  = lfsr_next(w_g);
    assign w_a8  = lfsr_adv8(w_g);
    assign w_a16 = lfsr_adv8(w_a8);
    assign w_a32 = lfsr_adv16(lfsr_guard(w_a16));

    always_comb begin
        o_state = i_state;
        o_ctl   = '0;
        o_value = '0;
        case (i_word.action)
            ACT_RESEED: begin
                o_state.shift_register = lfsr_guard(i_seed);
            end
            ACT_REINIT: begin
                o_state.shift_register   = LFSR_INIT;
                o_state.resync_bits_left = RESYNC_INIT;
                o_ctl.count_clear        = 1'b1;
            end
            ACT_RUN: begin
                case (i_mode)
                    MODE_BIT: begin
                        o_state.shift_register = w_a1;
                        o_value                = {31'd0, w_a1[15]};
                    end
                    MODE_BYTE: begin
                        o_state.shift_register = w_a8;
                        o_value                = {24'd0, w_a8[15:8]};
                    end
                    MODE_HALF: begin
                        o_state.shift_register = w_a16;
                        o_value                = {16'd0, w_a16};
                    end
                    MODE_WORD: begin
                        o_state.shift_register = w_a32;
                        o_value                = {w_a16, w_a32};
                    end
                    MODE_FOLLOW: begin
                        if (i_state.resync_bits_left != 5'd0) begin
                            o_state.shift_register =
                                {i_word.data_byte, i_state.shift_register[15:8]};
                            o_state.resync_bits_left =
                                (i_state.resync_bits_left > RESYNC_BYTE) ?
                                (i_state.resync_bits_left - RESYNC_BYTE) : 5'd0;
                        end else if (i_word.data_byte != w_a8[15:8]) begin
                            o_state.shift_register   = {i_word.data_byte, 8'h00};
                            o_state.resync_bits_left = RESYNC_BYTE;
                            o_ctl.count_inc          = 1'b1;
                        end else begin
                            o_state.shift_register = w_a8;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            default: begin
            end
        endcase
    end

endmodule

[rtl/prbs16_generator_checker.sv]
// prbs16_generator_checker: top level, input/output word registers, config and error count.
// Depends on prbs16_pkg and prbs16_step.
//
//  channel | direction | handshake                  | payload
//  in      | in        | i_in_valid / o_in_ready    | i_in_word (t_in_word)
//  out     | out       | o_out_valid / i_out_ready  | o_out_word (t_out_word)
//  cfg     | in        | i_cfg_valid / o_cfg_ready  | i_cfg_index, i_cfg_data
//
// One word per clock sustained while the output is not stalled; an accepted word passes
// from the input word register into the output word register, where o_out_valid rises.
// All stepping (up to 32 LFSR shifts) is unrolled XOR logic between the input word
// register and the output word register.
// Synchronous active-low reset restores mode, seed, LFSR, resync count and error count.
// A stalled output holds its word; the input register keeps accepting as long as the
// output register frees up in the same cycle. Config is always ready.
module prbs16_generator_checker #(
    parameter int COUNT_WIDTH = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  prbs16_pkg::t_in_word    i_in_word,
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output prbs16_pkg::t_out_word   o_out_word,
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [1:0]              i_cfg_index,
    input  logic [15:0]             i_cfg_data
);
    import prbs16_pkg::*;

    logic                   r_in_valid;
    t_in_word               r_in_word;
    logic                   r_out_valid;
    t_out_word              r_out_word;
    logic [2:0]             r_mode;
    logic [15:0]            r_seed;
    t_lfsr_state            r_state;
    logic [COUNT_WIDTH-1:0] r_count;

    t_lfsr_state            n_state;
    logic [COUNT_WIDTH-1:0] n_count;
    t_step_ctl              w_ctl;
    logic [31:0]            w_value;
    logic [31:0]            w_count_ext;
    logic                   w_adv;

    assign w_adv       = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || w_adv;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;
    assign o_cfg_ready = 1'b1;

    prbs16_step u_step (
        .i_mode  (r_mode),
        .i_seed  (r_seed),
        .i_word  (r_in_word),
        .i_state (r_state),
        .o_state (n_state),
        .o_ctl   (w_ctl),
        .o_value (w_value)
    );

    always_comb begin
        n_count = r_count;
        if (w_ctl.count_clear) begin
            n_count = '0;
        end else if (w_ctl.count_inc && (r_count != {COUNT_WIDTH{1'b1}})) begin
            n_count = r_count + COUNT_WIDTH'(1);
        end
        w_count_ext = 32'(n_count);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_mode      <= MODE_RESET;
            r_seed      <= LFSR_INIT;
            r_state     <= '{shift_register: LFSR_INIT, resync_bits_left: RESYNC_INIT};
            r_count     <= '0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (w_adv) begin
                r_out_valid <= 1'b1;
                r_state     <= n_state;
                r_count     <= n_count;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    REG_MODE: r_mode <= i_cfg_data[2:0];
                    REG_SEED: r_seed <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_word <= i_in_word;
        end
        if (w_adv) begin
            r_out_word.random_value <= w_value;
            r_out_word.follow_error <= w_ctl.count_inc;
            r_out_word.errors_seen  <= (w_count_ext > 32'h0000_FFFF) ?
                                       16'hFFFF : w_count_ext[15:0];
            r_out_word.resyncing    <= (n_state.resync_bits_left != 5'd0);
        end
    end

    a_ferr_resync: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_word.follow_error |->
            o_out_word.resyncing && (o_out_word.random_value == 32'd0))
        else $error("follow error without resync or with nonzero value");

    a_resync_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.resync_bits_left <= RESYNC_INIT)
        else $error("resync count out of range");

    a_adv_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_adv |=> r_out_valid)
        else $error("processed word did not reach output register");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_adv && !w_ctl.count_clear && !w_ctl.count_inc |=> $stable(r_count))
        else $error("error count changed without a mismatch");

endmodule

[sim/prbs16_monitor.sv]
`timescale 1ns / 100ps
// prbs16_monitor: watches the in, out and config channels of prbs16_generator_checker,
// predicts every output word from its own LFSR state and compares field by field.
// Depends on prbs16_pkg; instantiated by tb.
module prbs16_monitor #(
    parameter int COUNT_WIDTH = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    input  logic                    i_in_ready,
    input  prbs16_pkg::t_in_word    i_in_word,
    input  logic                    i_out_valid,
    input  logic                    i_out_ready,
    input  prbs16_pkg::t_out_word   i_out_word,
    input  logic                    i_cfg_valid,
    input  logic                    i_cfg_ready,
    input  logic [1:0]              i_cfg_index,
    input  logic [15:0]             i_cfg_data,
    output int                      o_fail_count,
    output int                      o_pending
);

    import prbs16_pkg::*;

    logic [2:0]             cur_mode;
    logic [15:0]            cur_seed;
    logic [15:0]            lfsr;
    logic [COUNT_WIDTH-1:0] err_count;
    logic [4:0]             resync_left;

    t_out_word predicted_words[$];
    t_out_word want_word;
    t_out_word got_word;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    task automatic walk_lfsr(input int steps, output logic [15:0] r);
        if (lfsr == 16'h0000) begin
            lfsr = LFSR_INIT;
        end
        for (int i = 0; i < steps; i++) begin
            lfsr = {lfsr[0] ^ lfsr[2] ^ lfsr[3] ^ lfsr[5], lfsr[15:1]};
        end
        r = lfsr;
    endtask

    task automatic predict_word(input t_in_word w, output t_out_word o);
        logic [15:0] hi;
        logic [15:0] lo;
        logic [15:0] r;
        logic [31:0] wide;
        o = '0;
        case (w.action)
            ACT_RESEED: begin
                lfsr = (cur_seed == 16'h0000) ? LFSR_INIT : cur_seed;
            end
            ACT_REINIT: begin
                lfsr        = LFSR_INIT;
                err_count   = '0;
                resync_left = RESYNC_INIT;
            end
            ACT_RUN: begin
                case (cur_mode)
                    MODE_BIT: begin
                        walk_lfsr(1, r);
                        o.random_value = {31'b0, r[15]};
                    end
                    MODE_BYTE: begin
                        walk_lfsr(8, r);
                        o.random_value = {24'b0, r[15:8]};
                    end
                    MODE_HALF: begin
                        walk_lfsr(16, r);
                        o.random_value = {16'b0, r};
                    end
                    MODE_WORD: begin
                        walk_lfsr(16, hi);
                        walk_lfsr(16, lo);
                        o.random_value = {hi, lo};
                    end
                    MODE_FOLLOW: begin
                        if (resync_left != '0) begin
                            lfsr        = {w.data_byte, lfsr[15:8]};
                            resync_left = (resync_left > RESYNC_BYTE) ?
                                          resync_left - RESYNC_BYTE : '0;
                        end else begin
                            walk_lfsr(8, r);
                            if (w.data_byte != r[15:8]) begin
                                lfsr        = {w.data_byte, 8'h00};
                                resync_left = RESYNC_BYTE;
                                if (err_count != '1) begin
                                    err_count++;
                                end
                                o.follow_error = 1'b1;
                            end
                        end
                    end
                    default: ;
                endcase
            end
            default: ;
        endcase
        wide          = 32'(err_count);
        o.errors_seen = (wide > 32'h0000_FFFF) ? 16'hFFFF : wide[15:0];
        o.resyncing   = (resync_left != '0);
    endtask

    task automatic note_mismatch(input string field, input logic [31:0] want,
                                 input logic [31:0] got);
        o_fail_count++;
        if (o_fail_count <= 10) begin
            $display("%0t: mismatch on %s: expected %h, got %h", $realtime, field, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cur_mode    = MODE_RESET;
            cur_seed    = 16'h0001;
            lfsr        = LFSR_INIT;
            err_count   = '0;
            resync_left = RESYNC_INIT;
            predicted_words.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    REG_MODE: cur_mode = i_cfg_data[2:0];
                    REG_SEED: cur_seed = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready) begin
                predict_word(i_in_word, want_word);
                predicted_words.push_back(want_word);
            end
            if (i_out_valid && i_out_ready) begin
                got_word = i_out_word;
                if (predicted_words.size() == 0) begin
                    note_mismatch("unexpected word", '0, 32'(got_word));
                end else begin
                    want_word = predicted_words.pop_front();
                    if (got_word.random_value != want_word.random_value)
                        note_mismatch("random_value", want_word.random_value,
                                      got_word.random_value);
                    if (got_word.follow_error != want_word.follow_error)
                        note_mismatch("follow_error", 32'(want_word.follow_error),
                                      32'(got_word.follow_error));
                    if (got_word.errors_seen != want_word.errors_seen)
                        note_mismatch("errors_seen", 32'(want_word.errors_seen),
                                      32'(got_word.errors_seen));
                    if (got_word.resyncing != want_word.resyncing)
                        note_mismatch("resyncing", 32'(want_word.resyncing),
                                      32'(got_word.resyncing));
                end
            end
        end
        o_pending = predicted_words.size();
    end

endmodule

[sim/tb.sv]
`timescale 1ns / 100ps
// tb: stimulus and verdict for prbs16_generator_checker; directed words, random
// generation and follow-mode streams, then a short back-to-back noise burst and a mixed run.
// Depends on prbs16_pkg, prbs16_generator_checker and prbs16_monitor.
module tb;

    import prbs16_pkg::*;

    localparam int         COUNT_WIDTH  = 16;
    localparam int         CYCLE_LIMIT  = 1_000_000;
    localparam int         PHASE_WORDS  = 110;
    localparam int         BURST_WORDS  = 40;
    localparam logic [1:0] ACT_UNUSED   = 2'd3;
    localparam logic [2:0] MODE_SPARE_LO = 3'd5;
    localparam logic [2:0] MODE_SPARE_HI = 3'd7;
    localparam logic [1:0] REG_SPARE_LO = 2'd2;
    localparam logic [1:0] REG_SPARE_HI = 2'd3;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic        in_ready;
    t_in_word    in_word   = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    t_out_word   out_word;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [15:0] cfg_data  = '0;

    int          fail_count;
    int          pending;
    int          cycle_count = 0;
    int          words_sent  = 0;
    int          cfg_writes  = 0;
    bit          no_idle     = 1'b0;
    logic [15:0] seed_now    = 16'h0001;

    always #5 clk = ~clk;

    prbs16_generator_checker #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_word   (in_word),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_word  (out_word),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    prbs16_monitor #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_monitor (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in_word    (in_word),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_word   (out_word),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d words outstanding", cycle_count, pending);
            $display("*** FAILED ***");
            $finish;
        end
    end

    // sink side: random stall before each output word (none while no_idle is set)
    initial begin
        int stall;
        wait (rst_n);
        @(negedge clk);
        forever begin
            stall = no_idle ? 0 : $urandom_range(0, 14);
            if (stall > 0) begin
                out_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
            @(negedge clk);
        end
    end

    // called at a falling edge; returns at the falling edge after the accept
    task automatic send_word(input logic [1:0] act, input logic [7:0] data);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 14);
        cfg_valid <= 1'b0;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_word  <= '{action: act, data_byte: data};
        do @(posedge clk); while (!in_ready);
        @(negedge clk);
        words_sent++;
    endtask

    task automatic reconfigure(input logic [1:0] index, input logic [15:0] data);
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        if (index == REG_SEED) begin
            seed_now = data;
        end
        cfg_writes++;
    endtask

    function automatic logic [15:0] stream_adv8(input logic [15:0] r);
        logic [15:0] v;
        v = (r == 16'h0000) ? LFSR_INIT : r;
        for (int i = 0; i < 8; i++) begin
            v = {v[0] ^ v[2] ^ v[3] ^ v[5], v[15:1]};
        end
        return v;
    endfunction

    task automatic run_mixed(input int n_words);
        int pick;
        for (int k = 0; k < n_words; k++) begin
            pick = $urandom_range(0, 99);
            if (pick < 80) send_word(ACT_RUN, 8'($urandom));
            else if (pick < 88) send_word(ACT_RESEED, 8'($urandom));
            else if (pick < 94) send_word(ACT_REINIT, 8'($urandom));
            else send_word(ACT_UNUSED, 8'($urandom));
        end
    endtask

    // mostly a clean PRBS byte stream, with injected errors, reseeds and noise
    task automatic run_follow(input int n_words);
        int          k;
        int          pick;
        bit          synced;
        logic [15:0] stream;
        logic [15:0] nxt;
        logic [7:0]  bad;
        logic [7:0]  fill;
        k      = 0;
        synced = 1'b0;
        while (k < n_words) begin
            if (!synced) begin
                send_word(ACT_REINIT, 8'($urandom));
                stream = 16'($urandom);
                send_word(ACT_RUN, stream[7:0]);
                send_word(ACT_RUN, stream[15:8]);
                k += 3;
                synced = 1'b1;
            end else begin
                pick = $urandom_range(0, 99);
                if (pick < 6) begin
                    nxt  = stream_adv8(stream);
                    bad  = nxt[15:8] ^ 8'($urandom_range(1, 255));
                    fill = 8'($urandom);
                    send_word(ACT_RUN, bad);
                    send_word(ACT_RUN, fill);
                    stream = {fill, bad};
                    k += 2;
                end else if (pick < 9) begin
                    send_word(ACT_RESEED, 8'($urandom));
                    stream = (seed_now == 16'h0000) ? LFSR_INIT : seed_now;
                    k++;
                end else if (pick < 11) begin
                    send_word(ACT_UNUSED, 8'($urandom));
                    k++;
                end else if (pick < 13) begin
                    send_word(ACT_RUN, 8'($urandom));
                    synced = 1'b0;
                    k++;
                end else begin
                    stream = stream_adv8(stream);
                    send_word(ACT_RUN, stream[15:8]);
                    k++;
                end
            end
        end
    endtask

    initial begin
        logic [2:0]  mode_sel;
        logic [15:0] seed_sel;
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: reset settings, each mode, seed extremes, unused codes, zero register
        send_word(ACT_RUN, 8'h00);
        send_word(ACT_RUN, 8'hFF);
        reconfigure(REG_MODE, {13'h1FFF, MODE_BIT});
        send_word(ACT_RUN, 8'h00);
        send_word(ACT_RUN, 8'h00);
        send_word(ACT_RUN, 8'hFF);
        reconfigure(REG_MODE, {13'h0000, MODE_HALF});
        send_word(ACT_RUN, 8'h55);
        reconfigure(REG_MODE, {13'h0000, MODE_WORD});
        send_word(ACT_RUN, 8'hAA);
        reconfigure(REG_SEED, 16'h0000);
        send_word(ACT_RESEED, 8'h00);
        send_word(ACT_RUN, 8'h00);
        reconfigure(REG_SEED, 16'hFFFF);
        send_word(ACT_RESEED, 8'hFF);
        send_word(ACT_RUN, 8'h00);
        send_word(ACT_UNUSED, 8'hFF);
        reconfigure(REG_MODE, {13'h0000, MODE_SPARE_HI});
        send_word(ACT_RUN, 8'h0F);
        reconfigure(REG_MODE, {13'h0000, MODE_SPARE_LO});
        send_word(ACT_RUN, 8'hF0);
        reconfigure(REG_SPARE_HI, 16'hFFFF);
        reconfigure(REG_MODE, {13'h0000, MODE_FOLLOW});
        send_word(ACT_REINIT, 8'hFF);
        send_word(ACT_RUN, 8'h00);
        send_word(ACT_RUN, 8'h00);
        reconfigure(REG_MODE, {13'h0000, MODE_HALF});
        send_word(ACT_RUN, 8'h00);
        reconfigure(REG_MODE, {13'h0000, MODE_FOLLOW});
        send_word(ACT_REINIT, 8'h00);
        send_word(ACT_RUN, 8'hFF);
        send_word(ACT_RUN, 8'h00);
        send_word(ACT_RUN, 8'hFF);
        send_word(ACT_RUN, 8'h00);

        // random phases over several settings
        for (int p = 0; p < 16; p++) begin
            if (p < 8) mode_sel = 3'(p);
            else if ($urandom_range(0, 9) < 4) mode_sel = MODE_FOLLOW;
            else mode_sel = 3'($urandom_range(0, 7));
            if (p == 0) seed_sel = 16'h0000;
            else if (p == 1) seed_sel = 16'hFFFF;
            else if ($urandom_range(0, 7) == 0) seed_sel = 16'h0000;
            else seed_sel = 16'($urandom);
            reconfigure(REG_MODE, {13'($urandom), mode_sel});
            reconfigure(REG_SEED, seed_sel);
            if ($urandom_range(0, 1) == 1) begin
                reconfigure(2'($urandom_range(REG_SPARE_LO, REG_SPARE_HI)), 16'($urandom));
            end
            no_idle = ($urandom_range(0, 3) == 0);
            if (mode_sel == MODE_FOLLOW) run_follow(PHASE_WORDS);
            else run_mixed(PHASE_WORDS);
        end

        // back-to-back noise in follow mode: mismatch and resync words with no gaps
        reconfigure(REG_MODE, {13'h0000, MODE_FOLLOW});
        no_idle = 1'b1;
        send_word(ACT_REINIT, 8'h00);
        for (int k = 0; k < BURST_WORDS; k++) begin
            send_word(ACT_RUN, 8'($urandom));
        end
        no_idle = 1'b0;
        run_mixed(20);

        in_valid  <= 1'b0;
        cfg_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (10) @(negedge clk);

        $display("%0d words sent and %0d register writes: all modes, seeds, follow streams",
                 words_sent, cfg_writes);
        $display("with injected errors and a back-to-back noise burst; %0d failures",
                 fail_count);
        if (fail_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

[prbs16_generator_checker.f]
rtl/prbs16_pkg.sv
rtl/prbs16_step.sv
rtl/prbs16_generator_checker.sv
sim/prbs16_monitor.sv
sim/tb.sv
